/* hdl/assert_macros.svh */
// Assertion macros used by the median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define MF3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median filter check failed");

// Next-cycle implication, held off while in reset.
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

/* hdl/mf3_pkg.sv */
// Types, constants and compare functions of the 3x3 median filter.
package mf3_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int MAX_WIDTH     = 64;
    localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = 7;
    localparam int HEIGHT_BITS   = 12;
    localparam int CFG_DATA_BITS = 12;
    localparam int WIN_SIDE      = 3;
    localparam int OUT_DEPTH     = 8;
    localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int CREDIT_BITS   = OUT_PTR_BITS + 1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(64);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(64);

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [ADDR_BITS-1:0]  line_addr_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    typedef struct packed {
        pixel_t lo;
        pixel_t md;
        pixel_t hi;
    } column_t;

    typedef struct packed {
        logic   frame_end;
        pixel_t median;
    } result_t;

    function automatic pixel_t min2(input pixel_t a, input pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pixel_t max2(input pixel_t a, input pixel_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Three compare-exchange steps.
    function automatic column_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
        pixel_t  lo1;
        pixel_t  hi1;
        pixel_t  mid;
        column_t res;
        lo1    = min2(a, b);
        hi1    = max2(a, b);
        res.hi = max2(hi1, c);
        mid    = min2(hi1, c);
        res.lo = min2(lo1, mid);
        res.md = max2(lo1, mid);
        return res;
    endfunction

endpackage

/* hdl/median_filter_3x3_stream.sv */
// Streaming 3x3 median filter, one pixel per cycle sustained.
// Each median passes through the line store read, the column sort, the row-rank stage
// and the median stage into the queue. One line store read and write per pixel.
// Input stalls only when 8 results are owed to the output (queue plus pipeline).
// Reset: counters and pipeline valids clear, width and height return to 64;
// line stores and window hold no reset value and fill as pixels arrive.
`include "assert_macros.svh"

module median_filter_3x3_stream
    import mf3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // pixel channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PIXEL_BITS-1:0]    pixel_in,
    // median channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIXEL_BITS-1:0]    median_value,
    output logic                     frame_end,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken.
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0]  frame_width_reg;
    logic [HEIGHT_BITS-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Clamp to the supported frame size: width 3..MAX_WIDTH, height at least 3.
    logic [WIDTH_BITS-1:0]  width_eff;
    logic [HEIGHT_BITS-1:0] height_eff;

    always_comb
    begin
        if (frame_width_reg < WIDTH_BITS'(WIN_SIDE))
            width_eff = WIDTH_BITS'(WIN_SIDE);
        else if (frame_width_reg > WIDTH_BITS'(MAX_WIDTH))
            width_eff = WIDTH_BITS'(MAX_WIDTH);
        else
            width_eff = frame_width_reg;

        if (frame_height_reg < HEIGHT_BITS'(WIN_SIDE))
            height_eff = HEIGHT_BITS'(WIN_SIDE);
        else
            height_eff = frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Stage 0: raster position, line store read issue.
    // ------------------------------------------------------------------
    line_addr_t             column_reg;
    line_addr_t             column_next;
    logic [HEIGHT_BITS-1:0] row_reg;
    logic [HEIGHT_BITS-1:0] row_next;
    logic [CREDIT_BITS-1:0] credit_reg;
    logic [CREDIT_BITS-1:0] credit_next;

    logic in_fire;
    logic out_fire;
    logic last_col;
    logic last_row;
    logic emit;

    assign in_ready = (credit_reg < CREDIT_BITS'(OUT_DEPTH));
    assign in_fire  = in_valid && in_ready;

    assign last_col = ((WIDTH_BITS'(column_reg) + 1'b1) >= width_eff);
    assign last_row = (({1'b0, row_reg} + 1'b1) >= {1'b0, height_eff});
    // A full neighbourhood exists once two rows and two columns are behind us.
    assign emit     = (row_reg >= HEIGHT_BITS'(2)) && (column_reg >= ADDR_BITS'(2));

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                column_next = '0;
                row_next    = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    // Count results owed to the output: one per emitting pixel, freed on delivery.
    always_comb
    begin
        credit_next = credit_reg;
        if (in_fire && emit && !out_fire)
            credit_next = credit_reg + 1'b1;
        else if (!(in_fire && emit) && out_fire)
            credit_next = credit_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            credit_reg <= credit_next;
        end
    end

    // Stage 1 control and payload.
    logic       s1_valid_reg;
    logic       s1_emit_reg;
    logic       s1_end_reg;
    pixel_t     s1_pixel_reg;
    line_addr_t s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_end_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s1_emit_reg  <= in_fire && emit;
            s1_end_reg   <= last_col && last_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= pixel_in;
            s1_addr_reg  <= column_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read at acceptance, write back in the cycle after. The same
    // column comes round again no sooner than three transactions later, so
    // no forwarding is needed.
    // ------------------------------------------------------------------
    line_pair_t rd_pair;
    line_pair_t wr_pair;

    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = s1_pixel_reg;

    mf3_line_store u_line_store (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (column_reg),
        .rd_data (rd_pair),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_pair)
    );

    // ------------------------------------------------------------------
    // Stage 1: sort the incoming column and shift it into the window.
    // The window keeps columns sorted; the median does not need row order.
    // ------------------------------------------------------------------
    column_t window_reg [WIN_SIDE];
    logic    s2_valid_reg;
    logic    s2_end_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= sort3(rd_pair.upper, rd_pair.middle, s1_pixel_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_end_reg   <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_emit_reg;
            s2_end_reg   <= s1_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: largest low, middle middle, smallest high.
    // ------------------------------------------------------------------
    pixel_t lo_max_reg;
    pixel_t md_med_reg;
    pixel_t hi_min_reg;
    logic   s3_valid_reg;
    logic   s3_end_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            lo_max_reg <= max2(max2(window_reg[0].lo, window_reg[1].lo), window_reg[2].lo);
            md_med_reg <= med3(window_reg[0].md, window_reg[1].md, window_reg[2].md);
            hi_min_reg <= min2(min2(window_reg[0].hi, window_reg[1].hi), window_reg[2].hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_end_reg   <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_end_reg   <= s2_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: median of the three, pushed into the output queue. The credit
    // count keeps the queue from overflowing.
    // ------------------------------------------------------------------
    result_t push_result;
    result_t head_result;

    assign push_result.frame_end = s3_end_reg;
    assign push_result.median    = med3(lo_max_reg, md_med_reg, hi_min_reg);

    mf3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (push_result),
        .pop       (out_ready),
        .not_empty (out_valid),
        .head      (head_result)
    );

    assign out_fire     = out_valid && out_ready;
    assign median_value = head_result.median;
    assign frame_end    = head_result.frame_end;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MF3_ASSERT_IMPL(a_credit_bound, clk, rst_n, 1'b1, credit_reg <= CREDIT_BITS'(OUT_DEPTH))
    `MF3_ASSERT_IMPL(a_out_owed, clk, rst_n, out_valid, credit_reg != '0)
    `MF3_ASSERT_IMPL(a_emit_reaches_queue, clk, rst_n, in_fire && emit, ##3 s3_valid_reg)
    `MF3_ASSERT_NEXT(a_store_written, clk, rst_n, in_fire, s1_valid_reg)

endmodule

/* hdl/mf3_line_store.sv */
// Line store memory: one entry per column holding the two previous rows.
module mf3_line_store
    import mf3_pkg::*;
(
    input  logic       clk,
    input  logic       rd_en,
    input  line_addr_t rd_addr,
    output line_pair_t rd_data,
    input  logic       wr_en,
    input  line_addr_t wr_addr,
    input  line_pair_t wr_data
);

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read data until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/mf3_out_fifo.sv */
// Result queue in front of the output channel.
module mf3_out_fifo
    import mf3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    not_empty,
    output result_t head
);

    result_t                 mem [OUT_DEPTH];
    logic [OUT_PTR_BITS:0]   wr_ptr_reg;
    logic [OUT_PTR_BITS:0]   wr_ptr_next;
    logic [OUT_PTR_BITS:0]   rd_ptr_reg;
    logic [OUT_PTR_BITS:0]   rd_ptr_next;

    assign not_empty   = (wr_ptr_reg != rd_ptr_reg);
    assign head        = mem[rd_ptr_reg[OUT_PTR_BITS-1:0]];
    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (pop && not_empty) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg[OUT_PTR_BITS-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule
